// ----- src/fdd_pkg.sv -----
package fdd_pkg;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_SAT   = 2'd2,
    ST_SHORT = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    JOB_FWD,
    JOB_CEN,
    JOB_BWDA,
    JOB_BWDB,
    JOB_SHORT
  } job_e;

  typedef struct packed {
    logic shift;
    logic clear;
    logic gap;
    logic load;
    logic step;
    logic emit;
    logic emit_last;
    job_e kind;
  } cmd_t;

  typedef struct packed {
    logic den_zero;
    logic out_free;
  } sts_t;

endpackage

// ----- src/fdd_dp.sv -----
module fdd_dp #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  fdd_pkg::cmd_t          cmd_i,
  output fdd_pkg::sts_t          sts_o,
  input  logic [DATA_WIDTH-1:0]  x_i,
  input  logic [DATA_WIDTH-1:0]  f_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [DATA_WIDTH-1:0]  out_data_o,
  output logic [1:0]             out_status_o,
  output logic                   out_last_o
);

  localparam int W  = DATA_WIDTH;
  localparam int NW = W + 5;
  localparam int MW = W + 4;
  localparam int DW = W + 4;
  localparam int NB = MW + FRAC_BITS + 1;

  logic signed [W-1:0]  x_q [5];
  logic signed [W-1:0]  f_q [5];
  logic [W-1:0]         g_q [4];
  logic [W-1:0]         g_d [4];
  logic signed [NW-1:0] num_q, num_d;
  logic signed [NW-1:0] fe [5];
  logic [DW-1:0]        den_q, den_d;
  logic [W+1:0]         gsum;
  logic [MW-1:0]        mag;
  logic                 neg_q;
  logic [NB-1:0]        acc_q, acc_d;
  logic [DW-1:0]        rem_q, rem_d;
  logic [DW:0]          rem_sh;
  logic                 ge;
  logic [NB:0]          q1;
  logic [NB-1:0]        rounded, lim, val;
  logic                 sat;
  logic [W-1:0]         res;
  logic [1:0]           res_st;
  logic                 ovalid_q;
  logic [W-1:0]         odata_q;
  logic [1:0]           ost_q;
  logic                 olast_q;

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      fe[i] = NW'(f_q[i]);
    end
    for (int i = 0; i < 4; i++) begin
      logic signed [W:0] d;
      d = (W+1)'(x_q[i+1]) - (W+1)'(x_q[i]);
      g_d[i] = d[W] ? W'(-d) : W'(d);
    end
  end

  always_comb begin
    case (cmd_i.kind)
      fdd_pkg::JOB_FWD:  num_d = (fe[3] <<< 2) - (fe[2] + (fe[2] <<< 1)) - fe[4];
      fdd_pkg::JOB_CEN:  num_d = fe[0] - (fe[1] <<< 3) + (fe[3] <<< 3) - fe[4];
      fdd_pkg::JOB_BWDA: num_d = (fe[3] + (fe[3] <<< 1)) - (fe[2] <<< 2) + fe[1];
      fdd_pkg::JOB_BWDB: num_d = (fe[4] + (fe[4] <<< 1)) - (fe[3] <<< 2) + fe[2];
      default:           num_d = '0;
    endcase
  end

  always_comb begin
    gsum = (W+2)'(g_q[0]) + (W+2)'(g_q[1]) + (W+2)'(g_q[2]) + (W+2)'(g_q[3]);
    case (cmd_i.kind)
      fdd_pkg::JOB_CEN:  den_d = DW'(gsum) + (DW'(gsum) << 1);
      fdd_pkg::JOB_BWDA: den_d = DW'(g_q[1]) + DW'(g_q[2]);
      default:           den_d = DW'(g_q[2]) + DW'(g_q[3]);
    endcase
    mag = num_q[NW-1] ? MW'(-num_q) : MW'(num_q);
  end

  always_comb begin
    rem_sh = {rem_q, acc_q[NB-1]};
    ge     = rem_sh >= {1'b0, den_q};
    rem_d  = ge ? DW'(rem_sh - {1'b0, den_q}) : DW'(rem_sh);
    acc_d  = {acc_q[NB-2:0], ge};
  end

  always_comb begin
    q1      = {1'b0, acc_q} + (NB+1)'(1);
    rounded = q1[NB:1];
    lim     = (NB'(1) << (W - 1)) - NB'(!neg_q);
    sat     = rounded > lim;
    val     = sat ? lim : rounded;
    if (cmd_i.kind == fdd_pkg::JOB_SHORT) begin
      res    = '0;
      res_st = fdd_pkg::ST_SHORT;
    end else if (den_q == '0) begin
      res    = '0;
      res_st = fdd_pkg::ST_ZERO;
    end else begin
      res    = neg_q ? W'(-val[W-1:0]) : val[W-1:0];
      res_st = sat ? fdd_pkg::ST_SAT : fdd_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) begin
        x_q[i] <= '0;
        f_q[i] <= '0;
      end
      ovalid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        for (int i = 0; i < 5; i++) begin
          x_q[i] <= '0;
          f_q[i] <= '0;
        end
      end else if (cmd_i.shift) begin
        for (int i = 0; i < 4; i++) begin
          x_q[i] <= x_q[i+1];
          f_q[i] <= f_q[i+1];
        end
        x_q[4] <= x_i;
        f_q[4] <= f_i;
      end
      if (cmd_i.emit) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.gap) begin
      g_q   <= g_d;
      num_q <= num_d;
    end
    if (cmd_i.load) begin
      den_q <= den_d;
      neg_q <= num_q[NW-1];
      acc_q <= {mag, (FRAC_BITS+1)'(0)};
      rem_q <= '0;
    end else if (cmd_i.step) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
    if (cmd_i.emit) begin
      odata_q <= res;
      ost_q   <= res_st;
      olast_q <= cmd_i.emit_last;
    end
  end

  assign sts_o.den_zero = den_q == '0;
  assign sts_o.out_free = !ovalid_q || out_ready_i;
  assign out_valid_o    = ovalid_q;
  assign out_data_o     = odata_q;
  assign out_status_o   = ost_q;
  assign out_last_o     = olast_q;

endmodule

// ----- src/fdd_ctrl.sv -----
module fdd_ctrl #(
  parameter int STEPS = 53
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_last_i,
  output logic          in_ready_o,
  input  fdd_pkg::sts_t sts_i,
  output fdd_pkg::cmd_t cmd_o
);

  localparam int SW = $clog2(STEPS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GAP,
    S_LOAD,
    S_DIV,
    S_EMIT
  } state_e;

  state_e         state_q;
  fdd_pkg::job_e  kind_q;
  logic           final_q;
  logic [2:0]     cnt_q;
  logic [2:0]     left_q;
  logic [SW-1:0]  step_q;
  logic [2:0]     c_new;
  logic           accept;
  logic           emit_last;

  assign in_ready_o = state_q == S_IDLE;
  assign accept     = in_valid_i && in_ready_o;
  assign c_new      = (cnt_q == 3'd5) ? 3'd5 : cnt_q + 3'd1;
  assign emit_last  = (kind_q == fdd_pkg::JOB_BWDB) ||
                      (kind_q == fdd_pkg::JOB_SHORT && left_q == 3'd1);

  always_comb begin
    cmd_o           = '0;
    cmd_o.kind      = kind_q;
    cmd_o.shift     = accept;
    cmd_o.gap       = state_q == S_GAP;
    cmd_o.load      = state_q == S_LOAD;
    cmd_o.step      = state_q == S_DIV;
    cmd_o.emit      = state_q == S_EMIT && sts_i.out_free;
    cmd_o.emit_last = emit_last;
    cmd_o.clear     = cmd_o.emit && emit_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= fdd_pkg::JOB_FWD;
      final_q <= 1'b0;
      cnt_q   <= '0;
      left_q  <= '0;
      step_q  <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            cnt_q   <= c_new;
            final_q <= in_last_i;
            if (in_last_i && c_new < 3'd4) begin
              kind_q  <= fdd_pkg::JOB_SHORT;
              left_q  <= c_new;
              state_q <= S_EMIT;
            end else if (c_new == 3'd5) begin
              kind_q  <= fdd_pkg::JOB_CEN;
              state_q <= S_GAP;
            end else if (c_new >= 3'd3) begin
              kind_q  <= fdd_pkg::JOB_FWD;
              state_q <= S_GAP;
            end
          end
        end
        S_GAP: begin
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          step_q  <= SW'(STEPS - 1);
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (sts_i.den_zero || step_q == '0) begin
            state_q <= S_EMIT;
          end else begin
            step_q <= step_q - SW'(1);
          end
        end
        S_EMIT: begin
          if (sts_i.out_free) begin
            if (emit_last) begin
              cnt_q   <= '0;
              state_q <= S_IDLE;
            end else if (kind_q == fdd_pkg::JOB_SHORT) begin
              left_q <= left_q - 3'd1;
            end else if (kind_q == fdd_pkg::JOB_BWDA) begin
              kind_q  <= fdd_pkg::JOB_BWDB;
              state_q <= S_GAP;
            end else if (final_q) begin
              kind_q  <= fdd_pkg::JOB_BWDA;
              state_q <= S_GAP;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/finite_difference_first_derivative.sv -----
// Channel  Dir  tdata (low bit up)                  tuser     tlast
// s_axis   in   x_value, f_value, zero pad to bytes  -         last_sample
// m_axis   out  derivative, zero pad to bytes        status    last_result
//
// A sample is taken only while no earlier work is pending. A sample that yields a result
// keeps the block busy through its gap, load, divide and emit states, dividing in the
// one-bit-per-cycle restoring divider; no sample is taken until that result is emitted.
// A final sample yields up to three results, each with its own division; results of a
// too-short sequence need no division and leave one per cycle while the output is free.
// Reset clears the sample window and the count; a stalled result holds the block only
// once the next result is ready.
module finite_difference_first_derivative #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // x_value, f_value
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]   s_axis_tdata_i,
  input  logic                                s_axis_tlast_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // derivative
  output logic [((DATA_WIDTH+7)/8)*8-1:0]     m_axis_tdata_o,
  // status
  output logic [1:0]                          m_axis_tuser_o,
  output logic                                m_axis_tlast_o
);

  localparam int OW    = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int STEPS = DATA_WIDTH + 4 + FRAC_BITS + 1;

  fdd_pkg::cmd_t          cmd;
  fdd_pkg::sts_t          sts;
  logic [DATA_WIDTH-1:0]  deriv;

  fdd_ctrl #(
    .STEPS(STEPS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_last_i (s_axis_tlast_i),
    .in_ready_o(s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  fdd_dp #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .x_i         (s_axis_tdata_i[DATA_WIDTH-1:0]),
    .f_i         (s_axis_tdata_i[2*DATA_WIDTH-1:DATA_WIDTH]),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (deriv),
    .out_status_o(m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = OW'(deriv);

endmodule

// ----- src/fdd_chk.sv -----
module fdd_chk #(
  parameter int DATA_WIDTH = 32
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [((DATA_WIDTH+7)/8)*8-1:0]   m_axis_tdata_o,
  input logic [1:0]                        m_axis_tuser_o,
  input logic                              m_axis_tlast_o
);

  logic [DATA_WIDTH-1:0] d;
  assign d = m_axis_tdata_o[DATA_WIDTH-1:0];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("stalled transaction changed");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == fdd_pkg::ST_ZERO ||
      m_axis_tuser_o == fdd_pkg::ST_SHORT) |-> d == '0)
    else $error("flagged result is not zero");

  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == fdd_pkg::ST_SAT |->
      d[DATA_WIDTH-2:0] == {(DATA_WIDTH-1){~d[DATA_WIDTH-1]}})
    else $error("saturated result is not a bound");

endmodule

bind finite_difference_first_derivative fdd_chk #(
  .DATA_WIDTH(DATA_WIDTH)
) u_fdd_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o),
  .m_axis_tlast_o (m_axis_tlast_o)
);
